// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file of the cipher block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define TJSC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tjsc port check failed");

// Checked on every rising clock edge, reset included.
`define TJSC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tjsc port check failed during reset");

`endif

// File: src/tjsc_pkg.sv
// ----------------------------------------------------------------------------
// tjsc_pkg
// Types, codes and the round function shared by the cipher block's modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tjsc_pkg;

  // Request codes carried in the input channel's tuser.
  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_AD    = 2'd1;
  localparam logic [1:0] REQ_TEXT  = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_LOW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_TOP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT   = 3'd4;

  // Frame bits XORed into state word 1.
  localparam logic [31:0] FRAME_IV = 32'h0000_0010;
  localparam logic [31:0] FRAME_AD = 32'h0000_0030;
  localparam logic [31:0] FRAME_PC = 32'h0000_0050;

  localparam int unsigned ROUNDS_PER_PASS = 128;
  localparam int unsigned STATE_WORDS     = 4;
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned TDATA_W         = 40;
  localparam int unsigned TDATA_PAD       = 5;

  localparam logic [2:0] FULL_WORD_BYTES = 3'd4;

  typedef enum logic [1:0] {
    CMD_START,
    CMD_AD,
    CMD_TEXT
  } cmd_kind_t;

  // One classified request as it travels from the front end to the engine.
  typedef struct packed {
    cmd_kind_t   kind;
    logic [31:0] data;     // already masked to the valid bytes
    logic [2:0]  count;    // normalized to 1..4
    logic        partial;  // count below four
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_FINISH
  } back_state_t;

  // Thirty-two keyed rounds at once for one state word.
  function automatic logic [31:0] tj_feedback(input logic [31:0] a, input logic [31:0] b,
                                              input logic [31:0] c, input logic [31:0] kw);
    logic [63:0] ba;
    logic [63:0] cb;
    ba = {b, a};
    cb = {c, b};
    return ba[46:15] ^ ~(cb[37:6] & cb[52:21]) ^ cb[58:27] ^ kw;
  endfunction

  // Mask of the low count bytes; count is 1..4.
  function automatic logic [31:0] byte_mask(input logic [2:0] count);
    logic [31:0] m;
    case (count)
      3'd1:    m = 32'h0000_00FF;
      3'd2:    m = 32'h0000_FFFF;
      3'd3:    m = 32'h00FF_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

// File: src/tjsc_front.sv
// ----------------------------------------------------------------------------
// tjsc_front
// Decodes incoming requests, normalizes the byte count and masks the data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tjsc_front import tjsc_pkg::*; (
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  req_type,
  input  logic [31:0] data_word,
  input  logic [2:0]  byte_count,
  input  logic        q_full,
  output logic        push,
  output cmd_t        cmd
);

  logic [2:0] count_n;
  logic       known;

  // Unknown request codes are taken and dropped.
  assign in_tready = !q_full;

  always_comb begin
    if (byte_count == 3'd0 || byte_count > FULL_WORD_BYTES) begin
      count_n = FULL_WORD_BYTES;
    end else begin
      count_n = byte_count;
    end
  end

  always_comb begin
    cmd.kind    = CMD_START;
    known       = 1'b1;
    case (req_type)
      REQ_START: cmd.kind = CMD_START;
      REQ_AD:    cmd.kind = CMD_AD;
      REQ_TEXT:  cmd.kind = CMD_TEXT;
      default:   known    = 1'b0;
    endcase
    cmd.data    = data_word & byte_mask(count_n);
    cmd.count   = count_n;
    cmd.partial = (count_n != FULL_WORD_BYTES);
  end

  assign push = in_tvalid && in_tready && known;

endmodule

// File: src/tjsc_queue.sv
// ----------------------------------------------------------------------------
// tjsc_queue
// Short request queue between the front end and the permutation engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tjsc_queue import tjsc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic cmd_valid,
  output cmd_t head_cmd
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

  cmd_t             entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == DEPTH_C);
  assign cmd_valid = (count_r != '0);
  assign head_cmd  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: src/tjsc_back.sv
// ----------------------------------------------------------------------------
// tjsc_back
// Permutation engine: one 32-round word update per cycle, absorb and output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tjsc_back import tjsc_pkg::*; #(
  parameter int unsigned ROUNDS_LONG  = 1024,
  parameter int unsigned ROUNDS_SHORT = 640
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cmd_valid,
  input  cmd_t         cmd,
  output logic         cmd_pop,
  input  logic [127:0] key,
  input  logic [95:0]  nonce,
  input  logic         decrypt,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [31:0]  out_text,
  output logic [2:0]   out_bytes
);

  localparam int unsigned STEPS_LONG  =
    ((ROUNDS_LONG + ROUNDS_PER_PASS - 1) / ROUNDS_PER_PASS) * STATE_WORDS;
  localparam int unsigned STEPS_SHORT =
    ((ROUNDS_SHORT + ROUNDS_PER_PASS - 1) / ROUNDS_PER_PASS) * STATE_WORDS;
  localparam int unsigned STEPS_MAX   = (STEPS_LONG > STEPS_SHORT) ? STEPS_LONG : STEPS_SHORT;
  localparam int unsigned CNT_W       = $clog2(STEPS_MAX);
  localparam logic [CNT_W-1:0] LAST_LONG  = CNT_W'(STEPS_LONG - 1);
  localparam logic [CNT_W-1:0] LAST_SHORT = CNT_W'(STEPS_SHORT - 1);

  // Start sequence: the long update, then one short update per nonce word.
  localparam logic [1:0] PH_LONG  = 2'd0;
  localparam logic [1:0] PH_NW0   = 2'd1;
  localparam logic [1:0] PH_NW1   = 2'd2;
  localparam logic [1:0] PH_LAST  = 2'd3;

  back_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] last_step;
  logic             long_r, long_nxt;
  logic [1:0]       phase_r, phase_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [31:0]      w_r [STATE_WORDS];
  logic [31:0]      w_nxt [STATE_WORDS];
  logic             out_valid_r, out_valid_nxt;
  logic [31:0]      out_text_r, out_text_nxt;
  logic [2:0]       out_bytes_r, out_bytes_nxt;
  logic             slot_free;
  logic [31:0]      key_word;
  logic [31:0]      nonce_word;
  logic [31:0]      result;
  logic [31:0]      count_word;

  assign last_step  = long_r ? LAST_LONG : LAST_SHORT;
  assign slot_free  = !out_valid_r || out_ready;
  assign key_word   = key[{cnt_r[1:0], 5'd0} +: 32];
  assign result     = (w_r[2] & byte_mask(cmd_r.count)) ^ cmd_r.data;
  assign count_word = {29'd0, cmd_r.count};

  always_comb begin
    case (phase_r)
      PH_NW0:  nonce_word = nonce[31:0];
      PH_NW1:  nonce_word = nonce[63:32];
      default: nonce_word = nonce[95:64];
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (cmd_valid) begin
          state_nxt = BK_RUN;
        end
      end
      BK_RUN: begin
        if (cnt_r == last_step) begin
          state_nxt = BK_FINISH;
        end
      end
      BK_FINISH: begin
        case (cmd_r.kind)
          CMD_START: state_nxt = (phase_r == PH_LAST) ? BK_IDLE : BK_RUN;
          CMD_TEXT:  state_nxt = slot_free ? BK_IDLE : BK_FINISH;
          default:   state_nxt = BK_IDLE;
        endcase
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    cmd_pop       = 1'b0;
    cnt_nxt       = cnt_r;
    long_nxt      = long_r;
    phase_nxt     = phase_r;
    cmd_nxt       = cmd_r;
    w_nxt         = w_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_text_nxt  = out_text_r;
    out_bytes_nxt = out_bytes_r;
    case (state_r)
      BK_IDLE: begin
        if (cmd_valid) begin
          cmd_pop   = 1'b1;
          cmd_nxt   = cmd;
          cnt_nxt   = '0;
          phase_nxt = PH_LONG;
          case (cmd.kind)
            CMD_START: begin
              long_nxt = 1'b1;
              for (int i = 0; i < STATE_WORDS; i++) begin
                w_nxt[i] = '0;
              end
            end
            CMD_AD: begin
              long_nxt = 1'b0;
              w_nxt[1] = w_r[1] ^ FRAME_AD;
            end
            default: begin
              long_nxt = 1'b1;
              w_nxt[1] = w_r[1] ^ FRAME_PC;
            end
          endcase
        end
      end
      BK_RUN: begin
        // The word under update always sits in slot 0; the words rotate.
        w_nxt[0] = w_r[1];
        w_nxt[1] = w_r[2];
        w_nxt[2] = w_r[3];
        w_nxt[3] = w_r[0] ^ tj_feedback(w_r[1], w_r[2], w_r[3], key_word);
        cnt_nxt  = (cnt_r == last_step) ? '0 : cnt_r + 1'b1;
      end
      BK_FINISH: begin
        case (cmd_r.kind)
          CMD_START: begin
            long_nxt = 1'b0;
            if (phase_r == PH_LONG) begin
              w_nxt[1]  = w_r[1] ^ FRAME_IV;
              phase_nxt = PH_NW0;
            end else begin
              w_nxt[3] = w_r[3] ^ nonce_word;
              if (phase_r != PH_LAST) begin
                w_nxt[1]  = w_r[1] ^ FRAME_IV;
                phase_nxt = phase_r + 1'b1;
              end
            end
          end
          CMD_AD: begin
            w_nxt[3] = w_r[3] ^ cmd_r.data;
            if (cmd_r.partial) begin
              w_nxt[1] = w_r[1] ^ count_word;
            end
          end
          default: begin
            if (slot_free) begin
              w_nxt[3]      = w_r[3] ^ (decrypt ? result : cmd_r.data);
              if (cmd_r.partial) begin
                w_nxt[1] = w_r[1] ^ count_word;
              end
              out_valid_nxt = 1'b1;
              out_text_nxt  = result;
              out_bytes_nxt = cmd_r.count;
            end
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      cnt_r       <= '0;
      long_r      <= 1'b0;
      phase_r     <= PH_LONG;
      out_valid_r <= 1'b0;
      for (int i = 0; i < STATE_WORDS; i++) begin
        w_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      long_r      <= long_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      w_r         <= w_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    out_text_r  <= out_text_nxt;
    out_bytes_r <= out_bytes_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_text  = out_text_r;
  assign out_bytes = out_bytes_r;

endmodule

// File: src/tinyjambu_stream_cipher_top.sv
// ----------------------------------------------------------------------------
// tinyjambu_stream_cipher_top
// Timing: a taken text request is queued, popped by the idle engine, run through
//   the long update in the one-word round unit and sent from the output register.
// Flow: the engine works on one request at a time while the queue takes more;
//   text requests run the long update, associated-data requests the short one.
// Reset: synchronous, active low; clears state, queue pointers and configuration only.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// TinyJAMBU-128 keyed permutation engine for a stream of 32-bit words.
//
// The front end takes a request whenever its two-entry queue has room, checks
// the request code, clamps the byte count to 1..4 and masks off unused data
// bytes. Requests with an unknown code are taken and dropped without effect.
//
// The engine pops one request at a time. Each cycle of an update it applies
// 32 keyed rounds to one state word, so a pass over the 128-bit state updates
// the four words in turn and an update runs whole passes. The four state
// words rotate through a fixed update slot, which keeps the round logic free
// of any word-select multiplexing.
//
// A start request clears the state, runs the long update, then for each of
// the three nonce words adds the IV frame bits, runs the short update and
// absorbs the word. An associated-data request adds its frame bits, runs the
// short update and absorbs the masked word. A text request adds its frame
// bits, runs the long update and sends the data XORed with state word 2;
// the plaintext (input when encrypting, result when decrypting) is absorbed.
// A partial word also XORs its byte count into state word 1.
//
// The result sits in an output register; the engine stalls only when a new
// result is due while the previous one has not been taken. Configuration is
// accepted every cycle and must only be written while the block is idle.

module tinyjambu_stream_cipher_top import tjsc_pkg::*; #(
  parameter int unsigned ROUNDS_LONG  = 1024,
  parameter int unsigned ROUNDS_SHORT = 640
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Request channel.
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [TDATA_W-1:0]   in_tdata,   // [31:0] data_word, [34:32] byte_count
  input  logic [1:0]           in_tuser,   // [1:0] req_type
  // Result channel.
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [TDATA_W-1:0]   out_tdata,  // [31:0] text_out, [34:32] out_bytes
  // Register write channel.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  logic [63:0] key_low_r;
  logic [63:0] key_high_r;
  logic [63:0] nonce_low_r;
  logic [31:0] nonce_top_r;
  logic        decrypt_r;

  logic        q_push;
  cmd_t        q_push_cmd;
  logic        q_full;
  logic        q_pop;
  logic        q_valid;
  cmd_t        q_head;
  logic [31:0] res_text;
  logic [2:0]  res_bytes;

  // Register writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r   <= '0;
      key_high_r  <= '0;
      nonce_low_r <= '0;
      nonce_top_r <= '0;
      decrypt_r   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_KEY_LOW:   key_low_r   <= cfg_data;
        CFG_KEY_HIGH:  key_high_r  <= cfg_data;
        CFG_NONCE_LOW: nonce_low_r <= cfg_data;
        CFG_NONCE_TOP: nonce_top_r <= cfg_data[31:0];
        CFG_DECRYPT:   decrypt_r   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  tjsc_front u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .req_type   (in_tuser),
    .data_word  (in_tdata[31:0]),
    .byte_count (in_tdata[34:32]),
    .q_full     (q_full),
    .push       (q_push),
    .cmd        (q_push_cmd)
  );

  tjsc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .cmd_valid (q_valid),
    .head_cmd  (q_head)
  );

  tjsc_back #(
    .ROUNDS_LONG  (ROUNDS_LONG),
    .ROUNDS_SHORT (ROUNDS_SHORT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd       (q_head),
    .cmd_pop   (q_pop),
    .key       ({key_high_r, key_low_r}),
    .nonce     ({nonce_top_r, nonce_low_r}),
    .decrypt   (decrypt_r),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_text  (res_text),
    .out_bytes (res_bytes)
  );

  assign out_tdata = {{TDATA_PAD{1'b0}}, res_bytes, res_text};

endmodule

// File: src/tjsc_checker.sv
// ----------------------------------------------------------------------------
// tjsc_checker
// Port-level checks on the result channel of the cipher block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tjsc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  logic [31:0] res_text;
  logic [2:0]  res_bytes;
  logic        pad_zero;
  logic        upper_zero;

  assign res_text  = out_tdata[31:0];
  assign res_bytes = out_tdata[34:32];
  assign pad_zero  = (out_tdata[39:35] == 5'd0);

  always_comb begin
    case (res_bytes)
      3'd1:    upper_zero = (res_text[31:8] == 24'd0);
      3'd2:    upper_zero = (res_text[31:16] == 16'd0);
      3'd3:    upper_zero = (res_text[31:24] == 8'd0);
      3'd4:    upper_zero = 1'b1;
      default: upper_zero = 1'b0;
    endcase
  end

  // A result waiting to be taken keeps its value.
  `TJSC_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))

  // The byte count is 1..4 and the padding bits are zero.
  `TJSC_ASSERT(a_out_count, out_tvalid |-> (res_bytes != 3'd0) && (res_bytes <= 3'd4) && pad_zero)

  // Bytes above the count are zero.
  `TJSC_ASSERT(a_out_unused_zero, out_tvalid |-> upper_zero)

  // Reset leaves no result pending.
  `TJSC_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_tvalid)

endmodule

bind tinyjambu_stream_cipher_top tjsc_checker u_tjsc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
